FILE: hw/rtl/uvhr_pkg.sv
// shared constants, types and arithmetic helpers for the heading rotation block
package uvhr_pkg;

    // fixed-point setup
    localparam int FRACTION_BITS = 14;
    localparam int CORDIC_STEPS  = 16;
    localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // datapath widths: general signed, vectoring, rotation residue
    localparam int WQ = 36;
    localparam int WA = 38;
    localparam int WR = 34;

    // latency of one cordic pipe (pre stage, steps, quadrant stage)
    localparam int LR = NSTEP + 2;
    // register stages from input register to output register, both included
    localparam int TOT = 3 * LR + 7;

    localparam logic signed [WQ-1:0] ONE = WQ'(1) <<< FRACTION_BITS;
    localparam int UNIT_SHIFT = 30 - FRACTION_BITS;
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032875;

    localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] TQ_TURN      = 32'hC000_0000;

    // heading components after the input register
    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic [15:0]        rnd;
    } side0_t;

    // heading plus deflected frame vector and azimuth
    typedef struct packed {
        logic signed [16:0]    x;
        logic signed [16:0]    y;
        logic signed [16:0]    z;
        logic signed [WQ-1:0]  rx;
        logic signed [WQ-1:0]  ry;
        logic signed [WQ-1:0]  rz;
        logic [31:0]           theta;
        logic                  z_up;
        logic                  z_down;
        logic                  z_zero;
    } side1_t;

    // heading plus frame vector, carried alongside the last cordic pair
    typedef struct packed {
        logic signed [16:0]    x;
        logic signed [16:0]    y;
        logic signed [16:0]    z;
        logic signed [WQ-1:0]  rx;
        logic signed [WQ-1:0]  ry;
        logic signed [WQ-1:0]  rz;
    } side2_t;

    // arctangent of 2^-i as a fraction of a turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // q30 product, floored
    function automatic logic signed [WQ-1:0] mulq(input logic signed [WQ-1:0] a,
                                                  input logic signed [WQ-1:0] b);
        logic signed [2*WQ-1:0] p;
        p = a * b;
        return WQ'(p >>> 30);
    endfunction

    // clamp to plus or minus one and to the 16-bit range
    function automatic logic [15:0] clamp_out(input logic signed [WQ-1:0] v);
        logic signed [WQ-1:0] t;
        t = v;
        if (t > ONE) t = ONE;
        if (t < -ONE) t = -ONE;
        if (t > WQ'(32767)) t = WQ'(32767);
        if (t < WQ'(-32768)) t = WQ'(-32768);
        return t[15:0];
    endfunction

endpackage

FILE: hw/rtl/unit_vector_heading_rotation.sv
// top level: deflects a unit heading by a polar and azimuthal angle
// One word is taken every clock cycle while no hold is in force, and results come out
// in order. Three cordic pipes lie in series: sine and cosine of the deflection and
// orientation beside the xy vectoring, then the polar vectoring, then sine and cosine
// of the polar and azimuth angles, followed by the product stages and the output
// stage. The whole pipeline holds while a finished word waits on m_tready, so no word
// is lost or repeated; s_tready is low only during such a hold.
module unit_vector_heading_rotation
    import uvhr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // old_x, old_y, old_z, deflection_angle, orientation_angle, random_fraction
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_x, new_y, new_z
    output logic [47:0] m_tdata
);

    logic en;
    logic valid_reg [0:TOT-1];

    // input register
    side0_t      in_reg;
    logic [15:0] defl_reg;
    logic [15:0] orient_reg;

    // first cordic group outputs
    logic signed [WQ-1:0] cd, sd, co, so;
    logic [31:0]          xy_angle;
    logic signed [WA-1:0] xy_mag;
    side0_t               d1_reg [0:LR-1];

    // gain correction and frame vector stage
    side1_t                 m1_reg;
    logic signed [WA+31:0]  rho_prod;
    logic signed [WQ-1:0]   rho;
    logic signed [WQ-1:0]   rho_hold_reg;
    logic [31:0]            theta_next;
    logic signed [WQ-1:0]   z_ext;

    // polar vectoring
    logic [31:0] phi_angle;
    logic signed [WA-1:0] phi_mag;
    side1_t      d2_reg [0:LR-1];

    // angle select stage
    logic [31:0] phi_reg;
    logic [31:0] theta_reg;
    side2_t      p_reg;

    // last cordic pair
    logic signed [WQ-1:0] cp, sp, ct, st;
    side2_t               d3_reg [0:LR-1];

    // product stages
    logic signed [WQ-1:0] f1_zc_reg, f1_a1_reg, f1_xc_reg, f1_yc_reg;
    logic signed [WQ-1:0] f1_ys_reg, f1_xs_reg, f1_rxs_reg;
    logic signed [WQ-1:0] f1_rzx_reg, f1_rzy_reg, f1_rzz_reg;
    logic signed [WQ-1:0] f1_ct_reg, f1_st_reg, f1_ry_reg;
    logic signed [WQ-1:0] f2_hx1_reg, f2_hy1_reg, f2_hz1_reg;
    logic signed [WQ-1:0] f2_zst_reg, f2_zct_reg, f2_xcs_reg, f2_ycc_reg;
    logic signed [WQ-1:0] f2_ys_reg, f2_xs_reg, f2_ry_reg;
    logic signed [WQ-1:0] f2_rzx_reg, f2_rzy_reg, f2_rzz_reg;
    logic signed [WQ-1:0] f3_hx1_reg, f3_hy1_reg, f3_hz1_reg;
    logic signed [WQ-1:0] f3_tx_reg, f3_ty_reg, f3_tz_reg;
    logic signed [WQ-1:0] f3_rzx_reg, f3_rzy_reg, f3_rzz_reg;
    logic signed [WQ-1:0] hx, hy, hz;
    logic [47:0]          out_reg;

    // global advance: move whenever the output slot is free or being taken
    assign en       = !valid_reg[TOT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[TOT-1];
    assign m_tdata  = out_reg;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOT; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < TOT; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    // input register, z negated on entry
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg.x   <= 17'(signed'(s_tdata[15:0]));
            in_reg.y   <= 17'(signed'(s_tdata[31:16]));
            in_reg.z   <= -17'(signed'(s_tdata[47:32]));
            defl_reg   <= s_tdata[63:48];
            orient_reg <= s_tdata[79:64];
            in_reg.rnd <= s_tdata[95:80];
        end
    end

    // deflection, orientation and xy angle in parallel
    uvhr_rot_pipe u_rot_defl (
        .aclk  (aclk),
        .en    (en),
        .turn  ({defl_reg, 16'h0000}),
        .cos_q (cd),
        .sin_q (sd)
    );

    uvhr_rot_pipe u_rot_orient (
        .aclk  (aclk),
        .en    (en),
        .turn  ({orient_reg, 16'h0000}),
        .cos_q (co),
        .sin_q (so)
    );

    uvhr_vec_pipe u_vec_xy (
        .aclk    (aclk),
        .en      (en),
        .a_in    (WA'(signed'({in_reg.x, 16'h0000}))),
        .b_in    (WA'(signed'({in_reg.y, 16'h0000}))),
        .angle   (xy_angle),
        .mag_raw (xy_mag)
    );

    // heading delay beside the first group
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg[0] <= in_reg;
            for (int i = 1; i < LR; i++) d1_reg[i] <= d1_reg[i-1];
        end
    end

    // radius, azimuth and polar special cases
    always_comb begin
        rho_prod = xy_mag * INV_GAIN_Q30;
        rho      = WQ'(rho_prod >>> 30);
        z_ext    = WQ'(d1_reg[LR-1].z);
        if (z_ext == ONE || z_ext == -ONE) begin
            theta_next = {d1_reg[LR-1].rnd, 16'h0000};
        end else if (d1_reg[LR-1].x == 0) begin
            theta_next = (d1_reg[LR-1].y > 0) ? QUARTER_TURN : TQ_TURN;
        end else begin
            theta_next = xy_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg.x      <= d1_reg[LR-1].x;
            m1_reg.y      <= d1_reg[LR-1].y;
            m1_reg.z      <= d1_reg[LR-1].z;
            m1_reg.rx     <= mulq(sd, co);
            m1_reg.ry     <= mulq(sd, so);
            m1_reg.rz     <= cd;
            m1_reg.theta  <= theta_next;
            m1_reg.z_up   <= (z_ext == ONE);
            m1_reg.z_down <= (z_ext == -ONE);
            m1_reg.z_zero <= (z_ext == 0);
            rho_hold_reg  <= rho;
        end
    end

    // polar angle from z and radius
    uvhr_vec_pipe u_vec_phi (
        .aclk    (aclk),
        .en      (en),
        .a_in    (WA'(signed'({m1_reg.z, 16'h0000}))),
        .b_in    (WA'(rho_hold_reg)),
        .angle   (phi_angle),
        .mag_raw (phi_mag)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg[0] <= m1_reg;
            for (int i = 1; i < LR; i++) d2_reg[i] <= d2_reg[i-1];
        end
    end

    // polar angle select
    always_ff @(posedge aclk) begin
        if (en) begin
            if (d2_reg[LR-1].z_up) begin
                phi_reg <= '0;
            end else if (d2_reg[LR-1].z_down) begin
                phi_reg <= HALF_TURN;
            end else if (d2_reg[LR-1].z_zero) begin
                phi_reg <= QUARTER_TURN;
            end else begin
                phi_reg <= phi_angle;
            end
            theta_reg <= d2_reg[LR-1].theta;
            p_reg.x   <= d2_reg[LR-1].x;
            p_reg.y   <= d2_reg[LR-1].y;
            p_reg.z   <= d2_reg[LR-1].z;
            p_reg.rx  <= d2_reg[LR-1].rx;
            p_reg.ry  <= d2_reg[LR-1].ry;
            p_reg.rz  <= d2_reg[LR-1].rz;
        end
    end

    // sines and cosines of polar and azimuth angles
    uvhr_rot_pipe u_rot_phi (
        .aclk  (aclk),
        .en    (en),
        .turn  (phi_reg),
        .cos_q (cp),
        .sin_q (sp)
    );

    uvhr_rot_pipe u_rot_theta (
        .aclk  (aclk),
        .en    (en),
        .turn  (theta_reg),
        .cos_q (ct),
        .sin_q (st)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            d3_reg[0] <= p_reg;
            for (int i = 1; i < LR; i++) d3_reg[i] <= d3_reg[i-1];
        end
    end

    // first products
    always_ff @(posedge aclk) begin
        if (en) begin
            f1_zc_reg  <= mulq(WQ'(d3_reg[LR-1].z), cp);
            f1_a1_reg  <= mulq(d3_reg[LR-1].rx, cp);
            f1_xc_reg  <= mulq(WQ'(d3_reg[LR-1].x), cp);
            f1_yc_reg  <= mulq(WQ'(d3_reg[LR-1].y), cp);
            f1_ys_reg  <= mulq(WQ'(d3_reg[LR-1].y), sp);
            f1_xs_reg  <= mulq(WQ'(d3_reg[LR-1].x), sp);
            f1_rxs_reg <= mulq(d3_reg[LR-1].rx, -sp);
            f1_rzx_reg <= mulq(d3_reg[LR-1].rz, WQ'(d3_reg[LR-1].x));
            f1_rzy_reg <= mulq(d3_reg[LR-1].rz, WQ'(d3_reg[LR-1].y));
            f1_rzz_reg <= mulq(d3_reg[LR-1].rz, WQ'(d3_reg[LR-1].z));
            f1_ct_reg  <= ct;
            f1_st_reg  <= st;
            f1_ry_reg  <= d3_reg[LR-1].ry;
        end
    end

    // second products, unit scaling as a shift
    always_ff @(posedge aclk) begin
        if (en) begin
            f2_hx1_reg <= mulq(f1_a1_reg, f1_ct_reg) >>> UNIT_SHIFT;
            f2_hy1_reg <= mulq(f1_a1_reg, f1_st_reg) >>> UNIT_SHIFT;
            f2_hz1_reg <= f1_rxs_reg >>> UNIT_SHIFT;
            f2_zst_reg <= mulq(f1_zc_reg, f1_st_reg);
            f2_zct_reg <= mulq(f1_zc_reg, f1_ct_reg);
            f2_xcs_reg <= mulq(f1_xc_reg, f1_st_reg);
            f2_ycc_reg <= mulq(f1_yc_reg, f1_ct_reg);
            f2_ys_reg  <= f1_ys_reg;
            f2_xs_reg  <= f1_xs_reg;
            f2_ry_reg  <= f1_ry_reg;
            f2_rzx_reg <= f1_rzx_reg;
            f2_rzy_reg <= f1_rzy_reg;
            f2_rzz_reg <= f1_rzz_reg;
        end
    end

    // frame y terms
    always_ff @(posedge aclk) begin
        if (en) begin
            f3_tx_reg  <= mulq(f2_ry_reg, -f2_ys_reg - f2_zst_reg);
            f3_ty_reg  <= mulq(f2_ry_reg, f2_xs_reg + f2_zct_reg);
            f3_tz_reg  <= mulq(f2_ry_reg, f2_xcs_reg - f2_ycc_reg);
            f3_hx1_reg <= f2_hx1_reg;
            f3_hy1_reg <= f2_hy1_reg;
            f3_hz1_reg <= f2_hz1_reg;
            f3_rzx_reg <= f2_rzx_reg;
            f3_rzy_reg <= f2_rzy_reg;
            f3_rzz_reg <= f2_rzz_reg;
        end
    end

    // sums, clamp, z negated back on exit
    always_comb begin
        hx = f3_hx1_reg + f3_tx_reg + f3_rzx_reg;
        hy = f3_hy1_reg + f3_ty_reg + f3_rzy_reg;
        hz = f3_hz1_reg + f3_tz_reg + f3_rzz_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {clamp_out(-hz), clamp_out(hy), clamp_out(hx)};
        end
    end

`ifndef SYNTH
    // a held pipeline keeps its first valid bit and the one before the output in place
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg[TOT-2]) && $stable(valid_reg[0]))
        else $error("valid bits moved during a hold");

    // a word accepted enters the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted word missing from first stage");

    // an output word only appears from the stage before it
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(valid_reg[TOT-2]))
        else $error("output valid without a word behind it");
`endif

endmodule

FILE: hw/rtl/uvhr_rot_pipe.sv
// pipelined cordic rotation: cosine and sine of a turn fraction in q30
module uvhr_rot_pipe
    import uvhr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [31:0]          turn,
    output logic signed [WQ-1:0] cos_q,
    output logic signed [WQ-1:0] sin_q
);

    logic signed [WQ-1:0] x_reg [0:NSTEP];
    logic signed [WQ-1:0] y_reg [0:NSTEP];
    logic signed [WR-1:0] r_reg [0:NSTEP];
    logic [1:0]           k_reg [0:NSTEP];
    logic signed [WQ-1:0] cos_reg;
    logic signed [WQ-1:0] sin_reg;

    logic [31:0] turn_off;
    logic [1:0]  k_next;
    logic [31:0] resid_next;

    // quadrant reduction
    always_comb begin
        turn_off   = turn + EIGHTH_TURN;
        k_next     = turn_off[31:30];
        resid_next = turn - {k_next, 30'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= WQ'(INV_GAIN_Q30);
            y_reg[0] <= '0;
            r_reg[0] <= WR'(signed'(resid_next));
            k_reg[0] <= k_next;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                k_reg[i+1] <= k_reg[i];
                if (r_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] - WR'(atan_turn(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] + WR'(atan_turn(i));
                end
            end
        end
    end

    // quadrant restore
    always_ff @(posedge aclk) begin
        if (en) begin
            case (k_reg[NSTEP])
                2'd0: begin
                    cos_reg <= x_reg[NSTEP];
                    sin_reg <= y_reg[NSTEP];
                end
                2'd1: begin
                    cos_reg <= -y_reg[NSTEP];
                    sin_reg <= x_reg[NSTEP];
                end
                2'd2: begin
                    cos_reg <= -x_reg[NSTEP];
                    sin_reg <= -y_reg[NSTEP];
                end
                default: begin
                    cos_reg <= y_reg[NSTEP];
                    sin_reg <= -x_reg[NSTEP];
                end
            endcase
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

FILE: hw/rtl/uvhr_vec_pipe.sv
// pipelined cordic vectoring: angle of (a, b) as a turn fraction and raw magnitude
module uvhr_vec_pipe
    import uvhr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [WA-1:0] a_in,
    input  logic signed [WA-1:0] b_in,
    output logic [31:0]          angle,
    output logic signed [WA-1:0] mag_raw
);

    logic signed [WA-1:0] a_reg [0:NSTEP];
    logic signed [WA-1:0] b_reg [0:NSTEP];
    logic [31:0]          ang_reg [0:NSTEP];
    logic [31:0]          angle_reg;
    logic signed [WA-1:0] mag_reg;

    // fold the left half plane over
    always_ff @(posedge aclk) begin
        if (en) begin
            if (a_in < 0) begin
                a_reg[0]   <= -a_in;
                b_reg[0]   <= -b_in;
                ang_reg[0] <= HALF_TURN;
            end else begin
                a_reg[0]   <= a_in;
                b_reg[0]   <= b_in;
                ang_reg[0] <= '0;
            end
        end
    end

    // one micro-rotation per stage, driving b towards zero
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (b_reg[i] > 0) begin
                    a_reg[i+1]   <= a_reg[i] + (b_reg[i] >>> i);
                    b_reg[i+1]   <= b_reg[i] - (a_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] + atan_turn(i);
                end else begin
                    a_reg[i+1]   <= a_reg[i] - (b_reg[i] >>> i);
                    b_reg[i+1]   <= b_reg[i] + (a_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] - atan_turn(i);
                end
            end
        end
    end

    // output stage, matches the rotation pipe latency
    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= ang_reg[NSTEP];
            mag_reg   <= a_reg[NSTEP];
        end
    end

    assign angle   = angle_reg;
    assign mag_raw = mag_reg;

endmodule
